@@ hdl/swkr_pkg.sv @@
// shared types and constants for the keyed-removal stack
// no dependencies; imported by swkr_ctrl and stack_with_keyed_removal_core
`default_nettype none

package swkr_pkg;

  localparam int FIELD_W     = 32;
  localparam int COUNT_OUT_W = 5;

  localparam int DEPTH_DEF      = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_SCAN,
    S_SHIFT,
    S_DELIVER
  } state_t;

  typedef struct packed {
    status_t                  status;
    logic [FIELD_W-1:0]       key;
    logic [FIELD_W-1:0]       value;
    logic [COUNT_OUT_W-1:0]   count;
  } res_t;

endpackage

`default_nettype wire

@@ hdl/swkr_mem.sv @@
// entry memory: one write port, one read port, registered read data
// depends on nothing but its parameters
`default_nettype none

module swkr_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hdl/swkr_ctrl.sv @@
// sequencer: push, pop, top-down key scan and shift-down removal
// uses swkr_pkg and drives one swkr_mem
`default_nettype none

module swkr_ctrl import swkr_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_op,
  input  wire logic [FIELD_W-1:0] in_key_in,
  input  wire logic [FIELD_W-1:0] in_value_in,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output res_t                    res
);

  localparam int KW = (KEY_BITS < FIELD_W) ? KEY_BITS : FIELD_W;
  localparam int VW = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;
  localparam int MW = KW + VW;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [KW-1:0] key_r, key_nxt;
  res_t          res_r, res_nxt;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [MW-1:0] mem_wdata, mem_rdata;
  logic [KW-1:0] rd_key;
  logic [VW-1:0] rd_val;

  logic          accept;
  op_t           op;
  logic          is_empty, is_full, match, at_top, shift_last, at_bottom;
  logic [AW-1:0] top_idx;

  swkr_mem #(
    .DEPTH (DEPTH),
    .WIDTH (MW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_key     = mem_rdata[MW-1:VW];
  assign rd_val     = mem_rdata[VW-1:0];
  assign op         = op_t'(in_op);
  assign in_stall   = (state_r != S_IDLE);
  assign accept     = in_valid && (state_r == S_IDLE);
  assign is_empty   = (count_r == '0);
  assign is_full    = (count_r == CW'(DEPTH));
  assign top_idx    = AW'(count_r - CW'(1));
  assign match      = (rd_key == key_r);
  assign at_top     = ((CW'(idx_r) + CW'(1)) == count_r);
  assign at_bottom  = (idx_r == '0);
  assign shift_last = ((CW'(idx_r) + CW'(2)) == count_r);
  assign res_valid  = (state_r == S_DELIVER);
  assign res        = res_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_POP:    state_nxt = is_empty ? S_DELIVER : S_POP_RD;
            OP_SEARCH: state_nxt = is_empty ? S_DELIVER : S_SCAN;
            default:   state_nxt = S_DELIVER;
          endcase
        end
      end
      S_POP_RD: state_nxt = S_DELIVER;
      S_SCAN: begin
        if (match) begin
          state_nxt = at_top ? S_DELIVER : S_SHIFT;
        end else if (at_bottom) begin
          state_nxt = S_DELIVER;
        end
      end
      S_SHIFT: begin
        if (shift_last) begin
          state_nxt = S_DELIVER;
        end
      end
      S_DELIVER: begin
        if (!res_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory control and datapath
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = top_idx;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    key_nxt   = key_r;
    res_nxt   = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt = '{status: ST_OK, key: '0, value: '0,
                      count: COUNT_OUT_W'(count_r)};
          unique case (op)
            OP_PUSH: begin
              if (is_full) begin
                res_nxt.status = ST_FULL;
              end else begin
                mem_we        = 1'b1;
                mem_waddr     = AW'(count_r);
                mem_wdata     = {in_key_in[KW-1:0], in_value_in[VW-1:0]};
                count_nxt     = count_r + CW'(1);
                res_nxt.count = COUNT_OUT_W'(count_nxt);
              end
            end
            OP_POP: begin
              if (is_empty) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                mem_re = 1'b1;
              end
            end
            OP_SEARCH: begin
              if (is_empty) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                mem_re  = 1'b1;
                idx_nxt = top_idx;
                key_nxt = in_key_in[KW-1:0];
              end
            end
            default: ;
          endcase
        end
      end
      S_POP_RD: begin
        count_nxt     = count_r - CW'(1);
        res_nxt.key   = FIELD_W'(rd_key);
        res_nxt.value = FIELD_W'(rd_val);
        res_nxt.count = COUNT_OUT_W'(count_nxt);
      end
      S_SCAN: begin
        if (match) begin
          res_nxt.value = FIELD_W'(rd_val);
          if (at_top) begin
            count_nxt     = count_r - CW'(1);
            res_nxt.count = COUNT_OUT_W'(count_nxt);
          end else begin
            // first entry above the hit moves down next
            mem_re    = 1'b1;
            mem_raddr = AW'(CW'(idx_r) + CW'(1));
          end
        end else if (at_bottom) begin
          res_nxt.status = ST_NOTFOUND;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r - AW'(1);
          idx_nxt   = idx_r - AW'(1);
        end
      end
      S_SHIFT: begin
        // read data is entry idx+1, lands in slot idx
        mem_we = 1'b1;
        if (shift_last) begin
          count_nxt     = count_r - CW'(1);
          res_nxt.count = COUNT_OUT_W'(count_nxt);
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(CW'(idx_r) + CW'(2));
          idx_nxt   = AW'(CW'(idx_r) + CW'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    key_r <= key_nxt;
    res_r <= res_nxt;
  end

endmodule

`default_nettype wire

@@ hdl/stack_with_keyed_removal_core.sv @@
// flow: push, no-op and full/empty results go from accept to the deliver state, then to
// the output register; pop passes a memory read state first; search scans entries from the
// top, shifts entries above the hit down, then delivers; a new item waits for idle;
// one entry memory with a single read port sets the pace, one entry per cycle
// reset: synchronous active-low rst_n empties the stack and drops any pending result;
// stored entries are not cleared, slots above the count are never read
`default_nettype none

module stack_with_keyed_removal_core import swkr_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             in_op,
  input  wire logic [FIELD_W-1:0]     in_key_in,
  input  wire logic [FIELD_W-1:0]     in_value_in,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [1:0]                  out_status,
  output logic [FIELD_W-1:0]          out_key_out,
  output logic [FIELD_W-1:0]          out_value_out,
  output logic [COUNT_OUT_W-1:0]      out_count_out
);

  // result beat handed from the sequencer to the output register
  logic res_valid;
  logic res_stall;
  res_t res;

  // output register state
  logic out_valid_r;
  res_t out_r;
  logic out_load;

  swkr_ctrl #(
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_key_in   (in_key_in),
    .in_value_in (in_value_in),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res         (res)
  );

  // the output register frees the sequencer: it can take the next beat
  // while a finished result still waits here for the consumer
  assign res_stall = out_valid_r && out_stall;
  assign out_load  = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload needs no reset, qualified by out_valid_r
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_r.status;
  assign out_key_out   = out_r.key;
  assign out_value_out = out_r.value;
  assign out_count_out = out_r.count;

endmodule

`default_nettype wire
